FILE: hw/rtl/rqs_pkg.sv
package rqs_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ID_W     = 16;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned DRAW_W   = 8;
  localparam int unsigned POL_W    = 2;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IX_W = 1;

  // Default number of cells in the queue.
  localparam int unsigned DEPTH_DEF = 16;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Insertion policy codes; the unused code behaves as FIFO.
  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_RAND = 2'd2;

  // Command codes.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] CFG_POLICY   = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_CAPACITY = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // How the cells pick the insertion point.
  typedef enum logic [1:0] {
    MODE_TAIL,
    MODE_POS,
    MODE_SORT
  } mode_t;

  // Control broadcast to every cell in the update cycle.
  typedef struct packed {
    logic  enq;
    logic  deq;
    mode_t mode;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/request_queue_scheduler_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_cmd, in_req_id, in_req_size, in_random_draw
// out       out_valid / out_ready   out_accepted, out_out_valid, out_out_id,
//                                   out_out_size, out_occupancy
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each item has an accept cycle and an update cycle: the accept cycle compares every
// cell against the new size and runs the first half of the draw remainder, and the
// update cycle finishes the remainder and moves the cell row; in_ready is low in the
// update cycle. The result sits in an output register; a stalled output holds the
// update cycle until the register is free. Reset (synchronous, active low) empties the
// queue and sets the policy to FIFO and the capacity to 16. cfg_ready is always high.
module request_queue_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = rqs_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [rqs_pkg::ID_W-1:0]       in_req_id,
  input  logic [rqs_pkg::SIZE_W-1:0]     in_req_size,
  input  logic [rqs_pkg::DRAW_W-1:0]     in_random_draw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_out_valid,
  output logic [rqs_pkg::ID_W-1:0]       out_out_id,
  output logic [rqs_pkg::SIZE_W-1:0]     out_out_size,
  output logic [rqs_pkg::OCC_W-1:0]      out_occupancy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rqs_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [rqs_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned D_W   = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > rqs_pkg::CAP_W) ? CNT_W : rqs_pkg::CAP_W;

  rqs_pkg::state_t state_r, state_nxt;

  logic [rqs_pkg::POL_W-1:0]  policy_r;
  logic [rqs_pkg::CAP_W-1:0]  capacity_r;
  logic [CNT_W-1:0]          count_r, count_nxt;

  logic                      cmd_r;
  logic [rqs_pkg::ID_W-1:0]   id_r;
  logic [rqs_pkg::SIZE_W-1:0] size_r;
  logic [D_W-1:0]            rem_r, rem_nxt;
  logic [3:0]                draw_lo_r;

  logic                      ov_r;
  logic                      o_acc_r;
  logic                      o_val_r;
  logic [rqs_pkg::ID_W-1:0]   o_id_r;
  logic [rqs_pkg::SIZE_W-1:0] o_size_r;
  logic [rqs_pkg::OCC_W-1:0]  o_occ_r;

  logic                      accept, apply_go, can_out, has_room, not_empty;
  logic [D_W-1:0]            divisor, rem_fin;
  logic [CNT_W-1:0]          pos;
  rqs_pkg::cell_ctl_t        ctl;

  logic [rqs_pkg::ID_W-1:0]   cell_id   [QUEUE_DEPTH];
  logic [rqs_pkg::SIZE_W-1:0] cell_size [QUEUE_DEPTH];
  logic                      found     [QUEUE_DEPTH+1];

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign can_out   = !ov_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= rqs_pkg::POL_FIFO;
      capacity_r <= rqs_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rqs_pkg::CFG_POLICY:   policy_r   <= cfg_data[rqs_pkg::POL_W-1:0];
        rqs_pkg::CFG_CAPACITY: capacity_r <= cfg_data[rqs_pkg::CAP_W-1:0];
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rqs_pkg::ST_IDLE:  if (in_valid) state_nxt = rqs_pkg::ST_APPLY;
      rqs_pkg::ST_APPLY: if (can_out) state_nxt = rqs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    apply_go = 1'b0;
    unique case (state_r)
      rqs_pkg::ST_IDLE:  in_ready = 1'b1;
      rqs_pkg::ST_APPLY: apply_go = can_out;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Random position: draw mod (count + 1), four bits per cycle.
  assign divisor = D_W'(count_r) + D_W'(1);

  rqs_rem_step #(.D_W(D_W)) u_rem_hi (
    .rem_in  ('0),
    .bits_in (in_random_draw[7:4]),
    .divisor (divisor),
    .rem_out (rem_nxt)
  );

  rqs_rem_step #(.D_W(D_W)) u_rem_lo (
    .rem_in  (rem_r),
    .bits_in (draw_lo_r),
    .divisor (divisor),
    .rem_out (rem_fin)
  );

  assign pos = CNT_W'(rem_fin);

  // Capture the item at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      id_r      <= in_req_id;
      size_r    <= in_req_size;
      rem_r     <= rem_nxt;
      draw_lo_r <= in_random_draw[3:0];
    end
  end

  // Room check against the capacity saturated to the cell count.
  assign has_room  = (CMP_W'(count_r) < CMP_W'(capacity_r)) &&
                     (count_r < CNT_W'(QUEUE_DEPTH));
  assign not_empty = count_r != '0;

  always_comb begin
    ctl.enq = apply_go && cmd_r == rqs_pkg::CMD_ENQ && has_room;
    ctl.deq = apply_go && cmd_r == rqs_pkg::CMD_DEQ && not_empty;
    if (policy_r == rqs_pkg::POL_SJF) begin
      ctl.mode = rqs_pkg::MODE_SORT;
    end else if (policy_r == rqs_pkg::POL_RAND) begin
      ctl.mode = rqs_pkg::MODE_POS;
    end else begin
      ctl.mode = rqs_pkg::MODE_TAIL;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The row of cells; position 0 is the head.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [rqs_pkg::ID_W-1:0]   l_id, r_id;
    logic [rqs_pkg::SIZE_W-1:0] l_size, r_size;

    if (i == 0) begin : g_head
      assign l_id   = '0;
      assign l_size = '0;
    end else begin : g_mid
      assign l_id   = cell_id[i-1];
      assign l_size = cell_size[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id   = '0;
      assign r_size = '0;
    end else begin : g_body
      assign r_id   = cell_id[i+1];
      assign r_size = cell_size[i+1];
    end

    rqs_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
      .clk        (clk),
      .cmp_en     (accept),
      .cmp_size   (in_req_size),
      .ctl        (ctl),
      .count      (count_r),
      .pos        (pos),
      .new_id     (id_r),
      .new_size   (size_r),
      .left_id    (l_id),
      .left_size  (l_size),
      .right_id   (r_id),
      .right_size (r_size),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .id_o       (cell_id[i]),
      .size_o     (cell_size[i])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (apply_go) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      o_acc_r  <= ctl.enq;
      o_val_r  <= ctl.deq;
      o_id_r   <= ctl.deq ? cell_id[0] : '0;
      o_size_r <= ctl.deq ? cell_size[0] : '0;
      o_occ_r  <= rqs_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = ov_r;
  assign out_accepted  = o_acc_r;
  assign out_out_valid = o_val_r;
  assign out_out_id    = o_id_r;
  assign out_out_size  = o_size_r;
  assign out_occupancy = o_occ_r;

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds the number of cells");

  // An accepted item always moves on to the update cycle.
  a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == rqs_pkg::ST_APPLY)
    else $error("accepted item did not reach the update cycle");

  // The count only moves in an update cycle.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !apply_go |=> $stable(count_r))
    else $error("queue count changed outside an update cycle");

  // A waiting result without an entry carries zero identifier and size.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_val_r) |-> (o_id_r == '0 && o_size_r == '0))
    else $error("result without an entry carries data");

  // A random position never lies beyond the current tail.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go |-> pos <= count_r)
    else $error("random insertion position beyond the tail");

endmodule

FILE: hw/rtl/rqs_rem_step.sv
// Four steps of a restoring remainder: shifts in four draw bits, one at a time,
// and subtracts the divisor whenever the partial remainder reaches it.
module rqs_rem_step #(
  parameter int unsigned D_W = 6
) (
  input  logic [D_W-1:0] rem_in,
  input  logic [3:0]     bits_in,
  input  logic [D_W-1:0] divisor,
  output logic [D_W-1:0] rem_out
);

  always_comb begin
    logic [D_W:0]   t;
    logic [D_W-1:0] r;
    r = rem_in;
    for (int b = 3; b >= 0; b--) begin
      t = {r, bits_in[b]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[D_W-1:0];
    end
    rem_out = r;
  end

endmodule

FILE: hw/rtl/rqs_cell.sv
// One queue position. It holds an identifier and a size, compares its size
// against an incoming request, and in the update cycle keeps its entry, takes
// the new request, or takes the entry of its left or right neighbour.
module rqs_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                      clk,
  input  logic                      cmp_en,
  input  logic [rqs_pkg::SIZE_W-1:0] cmp_size,
  input  rqs_pkg::cell_ctl_t        ctl,
  input  logic [CNT_W-1:0]          count,
  input  logic [CNT_W-1:0]          pos,
  input  logic [rqs_pkg::ID_W-1:0]   new_id,
  input  logic [rqs_pkg::SIZE_W-1:0] new_size,
  input  logic [rqs_pkg::ID_W-1:0]   left_id,
  input  logic [rqs_pkg::SIZE_W-1:0] left_size,
  input  logic [rqs_pkg::ID_W-1:0]   right_id,
  input  logic [rqs_pkg::SIZE_W-1:0] right_size,
  input  logic                      found_in,
  output logic                      found_out,
  output logic [rqs_pkg::ID_W-1:0]   id_o,
  output logic [rqs_pkg::SIZE_W-1:0] size_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [rqs_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [rqs_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic                      gt_r, gt_nxt;
  logic                      occupied, hit, take_new, take_left;

  // A held entry larger than the new size marks the sorted insertion point.
  assign occupied  = IDX_C < count;
  assign hit       = gt_r & occupied;
  assign found_out = found_in | hit;
  assign gt_nxt    = size_r > cmp_size;

  // Decide where this cell's next entry comes from.
  always_comb begin
    take_new  = 1'b0;
    take_left = 1'b0;
    unique case (ctl.mode)
      rqs_pkg::MODE_POS: begin
        take_new  = IDX_C == pos;
        take_left = IDX_C > pos;
      end
      rqs_pkg::MODE_SORT: begin
        take_new  = !found_in && (hit || IDX_C == count);
        take_left = found_in;
      end
      default: begin
        take_new  = IDX_C == count;
      end
    endcase
  end

  always_comb begin
    id_nxt   = id_r;
    size_nxt = size_r;
    if (ctl.enq) begin
      if (take_new) begin
        id_nxt   = new_id;
        size_nxt = new_size;
      end else if (take_left) begin
        id_nxt   = left_id;
        size_nxt = left_size;
      end
    end else if (ctl.deq) begin
      id_nxt   = right_id;
      size_nxt = right_size;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    size_r <= size_nxt;
    if (cmp_en) begin
      gt_r <= gt_nxt;
    end
  end

  assign id_o   = id_r;
  assign size_o = size_r;

endmodule

FILE: tb/request_queue_scheduler_unit_test.sv
module request_queue_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = rqs_pkg::DEPTH_DEF;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 48;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 300;
  localparam int QUIET_LIMIT    = 2000;

  // The spare policy code, which the block treats as FIFO.
  localparam logic [rqs_pkg::POL_W-1:0] POL_SPARE = 2'd3;

  // One result item as the block presents it.
  typedef struct packed {
    logic                       accepted;
    logic                       valid;
    logic [rqs_pkg::ID_W-1:0]   id;
    logic [rqs_pkg::SIZE_W-1:0] size;
    logic [rqs_pkg::OCC_W-1:0]  occ;
  } queue_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One line of the directed stimulus table.
  typedef struct {
    row_kind_t                    kind;
    logic                         cmd;
    logic [rqs_pkg::ID_W-1:0]     id;
    logic [rqs_pkg::SIZE_W-1:0]   size;
    logic [rqs_pkg::DRAW_W-1:0]   draw;
    bit                           typed;
    queue_result_t                want;
    logic [rqs_pkg::CFG_IX_W-1:0] cfg_ix;
    logic [rqs_pkg::CFG_W-1:0]    cfg_val;
  } plan_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_cmd;
  logic [rqs_pkg::ID_W-1:0]     in_req_id;
  logic [rqs_pkg::SIZE_W-1:0]   in_req_size;
  logic [rqs_pkg::DRAW_W-1:0]   in_random_draw;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_accepted;
  logic                         out_out_valid;
  logic [rqs_pkg::ID_W-1:0]     out_out_id;
  logic [rqs_pkg::SIZE_W-1:0]   out_out_size;
  logic [rqs_pkg::OCC_W-1:0]    out_occupancy;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [rqs_pkg::CFG_IX_W-1:0] cfg_index;
  logic [rqs_pkg::CFG_W-1:0]    cfg_data;

  request_queue_scheduler_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_req_id     (in_req_id),
    .in_req_size   (in_req_size),
    .in_random_draw(in_random_draw),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_accepted  (out_accepted),
    .out_out_valid (out_out_valid),
    .out_out_id    (out_out_id),
    .out_out_size  (out_out_size),
    .out_occupancy (out_occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the queue contents and the two registers.
  logic [rqs_pkg::ID_W-1:0]   shadow_ids   [DEPTH];
  logic [rqs_pkg::SIZE_W-1:0] shadow_sizes [DEPTH];
  int                         held;
  logic [rqs_pkg::POL_W-1:0]  pol_reg;
  logic [rqs_pkg::CAP_W-1:0]  cap_reg;

  queue_result_t pending_results [$];
  plan_row_t     plan [$];

  int  mismatch_count;
  int  results_seen;
  int  items_sent;
  int  settings_used;
  int  stored_count;
  int  dropped_count;
  int  taken_count;
  int  empty_count;
  bit  hold_off_request;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result of one request item and updates the shadow queue.
  function automatic queue_result_t apply_request(logic cmd, logic [rqs_pkg::ID_W-1:0] id,
                                                  logic [rqs_pkg::SIZE_W-1:0] size,
                                                  logic [rqs_pkg::DRAW_W-1:0] draw);
    queue_result_t r;
    int            slot;
    int            limit;
    bit            found;
    r     = '0;
    limit = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    if (cmd == rqs_pkg::CMD_ENQ) begin
      if (held < limit) begin
        slot = held;
        if (pol_reg == rqs_pkg::POL_SJF) begin
          // First held entry that is strictly larger, so ties keep arrival order.
          found = 1'b0;
          for (int i = 0; i < held; i++) begin
            if (!found && shadow_sizes[i] > size) begin
              slot  = i;
              found = 1'b1;
            end
          end
        end else if (pol_reg == rqs_pkg::POL_RAND) begin
          slot = int'(draw) % (held + 1);
        end
        for (int i = held; i > slot; i--) begin
          shadow_ids[i]   = shadow_ids[i-1];
          shadow_sizes[i] = shadow_sizes[i-1];
        end
        shadow_ids[slot]   = id;
        shadow_sizes[slot] = size;
        held++;
        r.accepted = 1'b1;
        stored_count++;
      end else begin
        dropped_count++;
      end
    end else begin
      if (held > 0) begin
        r.valid = 1'b1;
        r.id    = shadow_ids[0];
        r.size  = shadow_sizes[0];
        for (int i = 1; i < held; i++) begin
          shadow_ids[i-1]   = shadow_ids[i];
          shadow_sizes[i-1] = shadow_sizes[i];
        end
        held--;
        taken_count++;
      end else begin
        empty_count++;
      end
    end
    r.occ = rqs_pkg::OCC_W'(held);
    return r;
  endfunction

  function automatic queue_result_t res(logic acc, logic vld, logic [rqs_pkg::ID_W-1:0] id,
                                        logic [rqs_pkg::SIZE_W-1:0] size, int occ);
    queue_result_t r;
    r.accepted = acc;
    r.valid    = vld;
    r.id       = id;
    r.size     = size;
    r.occ      = rqs_pkg::OCC_W'(occ);
    return r;
  endfunction

  function automatic void plan_item(logic cmd, logic [rqs_pkg::ID_W-1:0] id,
                                    logic [rqs_pkg::SIZE_W-1:0] size,
                                    logic [rqs_pkg::DRAW_W-1:0] draw, bit typed = 1'b0,
                                    queue_result_t want = '0);
    plan_row_t row;
    row         = '{kind: ROW_ITEM, default: '0};
    row.cmd     = cmd;
    row.id      = id;
    row.size    = size;
    row.draw    = draw;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic [rqs_pkg::CFG_IX_W-1:0] ix,
                                   logic [rqs_pkg::CFG_W-1:0] val);
    plan_row_t row;
    row         = '{kind: ROW_CFG, default: '0};
    row.cfg_ix  = ix;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  // Offers one request item, records its expected result once it is taken,
  // then leaves the given number of idle cycles (none keeps valid high).
  task automatic send_item(logic cmd, logic [rqs_pkg::ID_W-1:0] id,
                           logic [rqs_pkg::SIZE_W-1:0] size,
                           logic [rqs_pkg::DRAW_W-1:0] draw, int gap, bit typed = 1'b0,
                           queue_result_t want = '0);
    queue_result_t predicted;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_req_id      <= id;
    in_req_size    <= size;
    in_random_draw <= draw;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(cmd, id, size, draw);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Register write; only issued while the queue has nothing in flight.
  task automatic write_reg(logic [rqs_pkg::CFG_IX_W-1:0] ix, logic [rqs_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (ix == rqs_pkg::CFG_POLICY) begin
      pol_reg = val[rqs_pkg::POL_W-1:0];
    end else begin
      cap_reg = val[rqs_pkg::CAP_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: a rotating ready pattern, changed now and then, plus one long hold-off.
  initial begin : receiver
    logic [7:0] pattern;
    int         tick;
    out_ready = 1'b0;
    pattern   = 8'hFF;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      tick++;
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = 8'hFF;
          1: pattern = 8'($urandom) | 8'h01;
          2: pattern = 8'hAA;
          default: pattern = 8'h81;
        endcase
      end
      out_ready <= pattern[tick % 8];
    end
  end

  // Result checker: each result is compared with the oldest expectation.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_accepted, out_out_valid, out_out_id, out_out_size, out_occupancy};
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: acc=%0d vld=%0d id=%h size=%h occ=%0d",
                 $time, got.accepted, got.valid, got.id, got.size, got.occ);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected acc=%0d vld=%0d id=%h size=%h occ=%0d",
                   $time, want.accepted, want.valid, want.id, want.size, want.occ);
          $display("%0t:           actual   acc=%0d vld=%0d id=%h size=%h occ=%0d",
                   $time, got.accepted, got.valid, got.id, got.size, got.occ);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if no handshake happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: directed table first, then random phases.
  initial begin : stimulus
    int                         directed_items;
    int                         gap;
    int                         burst_left;
    int                         enq_pct;
    bit                         bursty;
    logic [rqs_pkg::POL_W-1:0]  pol;
    logic [rqs_pkg::CAP_W-1:0]  cap;
    logic                       cmd;
    logic [rqs_pkg::SIZE_W-1:0] size;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = rqs_pkg::CMD_ENQ;
    in_req_id        = '0;
    in_req_size      = '0;
    in_random_draw   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = rqs_pkg::CFG_POLICY;
    cfg_data         = '0;
    hold_off_request = 1'b0;
    mismatch_count   = 0;
    results_seen     = 0;
    items_sent       = 0;
    settings_used    = 1;
    stored_count     = 0;
    dropped_count    = 0;
    taken_count      = 0;
    empty_count      = 0;
    held             = 0;
    pol_reg          = rqs_pkg::POL_FIFO;
    cap_reg          = rqs_pkg::CAP_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_ids[i]   = '0;
      shadow_sizes[i] = '0;
    end

    // Reset defaults, extreme fields and an empty dequeue.
    plan_item(rqs_pkg::CMD_DEQ, 16'h0000, 32'h0, 8'h00, 1, res(0, 0, 16'h0, 32'h0, 0));
    plan_item(rqs_pkg::CMD_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1,
              res(1, 0, 16'h0, 32'h0, 1));
    plan_item(rqs_pkg::CMD_ENQ, 16'h0000, 32'h0, 8'h00, 1, res(1, 0, 16'h0, 32'h0, 2));
    plan_item(rqs_pkg::CMD_DEQ, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1,
              res(0, 1, 16'hFFFF, 32'hFFFF_FFFF, 1));
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0, 1, res(0, 1, 16'h0, 32'h0, 0));
    // Capacity of one: the second enqueue finds the queue full.
    plan_cfg(rqs_pkg::CFG_CAPACITY, 5'd1);
    plan_item(rqs_pkg::CMD_ENQ, 16'h0001, 32'd5, 8'h00, 1, res(1, 0, 16'h0, 32'h0, 1));
    plan_item(rqs_pkg::CMD_ENQ, 16'h0002, 32'd6, 8'h00, 1, res(0, 0, 16'h0, 32'h0, 1));
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0, 1, res(0, 1, 16'h0001, 32'd5, 0));
    // Capacity zero drops every enqueue.
    plan_cfg(rqs_pkg::CFG_CAPACITY, 5'd0);
    plan_item(rqs_pkg::CMD_ENQ, 16'h0003, 32'd7, 8'h00, 1, res(0, 0, 16'h0, 32'h0, 0));
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0, 1, res(0, 0, 16'h0, 32'h0, 0));
    // Capacity above the depth saturates; shortest-first with a tie.
    plan_cfg(rqs_pkg::CFG_CAPACITY, 5'd31);
    plan_cfg(rqs_pkg::CFG_POLICY, {3'b111, rqs_pkg::POL_SJF});
    plan_item(rqs_pkg::CMD_ENQ, 16'd11, 32'd30, 8'h00);
    plan_item(rqs_pkg::CMD_ENQ, 16'd12, 32'd10, 8'h00);
    plan_item(rqs_pkg::CMD_ENQ, 16'd13, 32'd20, 8'h00);
    plan_item(rqs_pkg::CMD_ENQ, 16'd14, 32'd10, 8'h00);
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0);
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0);
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0);
    plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0);
    // Random placement, then shortest-first over the unsorted row.
    plan_cfg(rqs_pkg::CFG_POLICY, {3'b000, rqs_pkg::POL_RAND});
    plan_item(rqs_pkg::CMD_ENQ, 16'd21, 32'd40, 8'd0);
    plan_item(rqs_pkg::CMD_ENQ, 16'd22, 32'd5, 8'd255);
    plan_item(rqs_pkg::CMD_ENQ, 16'd23, 32'd25, 8'd128);
    plan_cfg(rqs_pkg::CFG_POLICY, {3'b000, rqs_pkg::POL_SJF});
    plan_item(rqs_pkg::CMD_ENQ, 16'd25, 32'd20, 8'd0);
    // The spare policy code appends like FIFO.
    plan_cfg(rqs_pkg::CFG_POLICY, {3'b010, POL_SPARE});
    plan_item(rqs_pkg::CMD_ENQ, 16'd26, 32'd1, 8'd7);
    repeat (5) plan_item(rqs_pkg::CMD_DEQ, 16'h0, 32'h0, 8'h0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (int r = 0; r < plan.size(); r++) begin
      if (plan[r].kind == ROW_CFG) begin
        wait_for_results();
        write_reg(plan[r].cfg_ix, plan[r].cfg_val);
        settings_used++;
      end else begin
        gap = (r == plan.size() - 1 || plan[r+1].kind == ROW_CFG) ? 1 : $urandom_range(0, 2);
        send_item(plan[r].cmd, plan[r].id, plan[r].size, plan[r].draw, gap,
                  plan[r].typed, plan[r].want);
      end
    end
    directed_items = items_sent;

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_results();
      pol = (phase < 4) ? rqs_pkg::POL_W'(phase) : rqs_pkg::POL_W'($urandom_range(0, 3));
      case (phase)
        0: cap = 5'd16;
        1: cap = 5'd31;
        2: cap = 5'd1;
        3: cap = 5'd4;
        default: begin
          case ($urandom_range(0, 4))
            0: cap = 5'd1;
            1: cap = 5'd16;
            2: cap = rqs_pkg::CAP_W'($urandom_range(0, 31));
            default: cap = rqs_pkg::CAP_W'($urandom_range(2, 15));
          endcase
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(rqs_pkg::CFG_POLICY, {3'($urandom), pol});
        write_reg(rqs_pkg::CFG_CAPACITY, cap);
      end else begin
        write_reg(rqs_pkg::CFG_CAPACITY, cap);
        write_reg(rqs_pkg::CFG_POLICY, {3'($urandom), pol});
      end
      settings_used++;

      enq_pct    = (phase == 3) ? 85 : $urandom_range(35, 80);
      bursty     = (phase != 2);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the receiver off for a long stretch while the sender keeps offering.
        if (phase == 3 && n == 8) begin
          hold_off_request = 1'b1;
        end
        cmd = ($urandom_range(0, 99) < enq_pct) ? rqs_pkg::CMD_ENQ : rqs_pkg::CMD_DEQ;
        case ($urandom_range(0, 3))
          0: size = rqs_pkg::SIZE_W'($urandom_range(0, 7));
          1: size = $urandom;
          2: size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          default: size = rqs_pkg::SIZE_W'($urandom_range(0, 1000));
        endcase
        if (n == PHASE_ITEMS - 1) begin
          gap = 1;
        end else if (!bursty) begin
          gap = 0;
        end else if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap = $urandom_range(1, 6);
        end
        send_item(cmd, rqs_pkg::ID_W'($urandom_range(0, 65535)), size,
                  rqs_pkg::DRAW_W'($urandom_range(0, 255)), gap);
      end
    end

    wait_for_results();

    $display("Ran %0d request items (%0d from the table) under %0d register settings;",
             items_sent, directed_items, settings_used);
    $display("%0d results checked; enqueues stored %0d, dropped %0d; dequeues %0d, empty %0d.",
             results_seen, stored_count, dropped_count, taken_count, empty_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
